FILE: hdl/ftdf_pkg.sv
// Shared definitions for the frequency-translating decimating FIR: parameter defaults,
// register map codes, reset values and the control group that drives the complex MAC.
// No dependencies.
package ftdf_pkg;

    localparam int MAX_TAPS_DEF        = 256;
    localparam int SAMPLE_BITS_DEF     = 16;
    localparam int TRIG_TABLE_BITS_DEF = 10;

    localparam int CNT_W     = 9;   // tap_count, decimation and the stream counters
    localparam int TAP_IDX_W = 8;
    localparam int PHASE_W   = 32;
    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = PADDR_W - 2;

    localparam logic [CNT_W-1:0] TAP_COUNT_RST  = CNT_W'(64);
    localparam logic [CNT_W-1:0] DECIMATION_RST = CNT_W'(1);

    localparam logic [REG_IDX_W-1:0] REG_TAP_COUNT  = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_DECIMATION = REG_IDX_W'(1);
    localparam logic [REG_IDX_W-1:0] REG_PHASE_STEP = REG_IDX_W'(2);

    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_TAP    = 1'b1;

    typedef struct packed {
        logic en;
        logic first;
        logic last;
    } t_mac_ctl;

endpackage

FILE: hdl/ftdf_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module ftdf_ram #(
    parameter int  WIDTH = 32,
    parameter int  DEPTH = 256,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/ftdf_cmac.sv
// Pipelined complex multiply-accumulate with round-half-up and saturation of the sum.
// Depends on ftdf_pkg (t_mac_ctl).
module ftdf_cmac #(
    parameter int SAMPLE_BITS = ftdf_pkg::SAMPLE_BITS_DEF,
    parameter int ACC_W       = 2 * ftdf_pkg::SAMPLE_BITS_DEF + 9
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ftdf_pkg::t_mac_ctl            i_ctl,
    input  logic signed [SAMPLE_BITS-1:0] i_xr,
    input  logic signed [SAMPLE_BITS-1:0] i_xi,
    input  logic signed [SAMPLE_BITS-1:0] i_tr,
    input  logic signed [SAMPLE_BITS-1:0] i_ti,
    output logic                          o_done,
    output logic signed [SAMPLE_BITS-1:0] o_yr,
    output logic signed [SAMPLE_BITS-1:0] o_yi
);
    import ftdf_pkg::*;

    localparam int PW   = 2 * SAMPLE_BITS;
    localparam int FRAC = SAMPLE_BITS - 1;
    localparam logic signed [ACC_W-1:0] HALF   = ACC_W'(1) <<< (FRAC - 1);
    localparam logic signed [ACC_W-1:0] SMAX_A = {{(ACC_W - FRAC){1'b0}}, {FRAC{1'b1}}};
    localparam logic signed [ACC_W-1:0] SMIN_A = ~SMAX_A;
    localparam logic signed [SAMPLE_BITS-1:0] SMAX_W = {1'b0, {FRAC{1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SMIN_W = {1'b1, {FRAC{1'b0}}};

    logic signed [PW-1:0]          r_rr, r_ii, r_ri, r_ir;
    logic                          r_v1, r_f1, r_l1, r_l2, r_done;
    logic signed [ACC_W-1:0]       r_acc_re, r_acc_im;
    logic signed [ACC_W-1:0]       sum_re, sum_im;
    logic signed [SAMPLE_BITS-1:0] r_yr, r_yi;

    function automatic logic signed [SAMPLE_BITS-1:0] round_sat(
        input logic signed [ACC_W-1:0] a
    );
        logic signed [ACC_W-1:0] t;
        logic signed [ACC_W-1:0] q;
        t = a + HALF;
        q = t >>> FRAC;
        if (q > SMAX_A) begin
            return SMAX_W;
        end else if (q < SMIN_A) begin
            return SMIN_W;
        end
        return q[SAMPLE_BITS-1:0];
    endfunction

    assign sum_re = ACC_W'(r_rr) - ACC_W'(r_ii);
    assign sum_im = ACC_W'(r_ri) + ACC_W'(r_ir);

    // products
    always_ff @(posedge i_clk) begin
        r_rr <= i_xr * i_tr;
        r_ii <= i_xi * i_ti;
        r_ri <= i_xr * i_ti;
        r_ir <= i_xi * i_tr;
        if (r_v1) begin
            r_acc_re <= r_f1 ? sum_re : r_acc_re + sum_re;
            r_acc_im <= r_f1 ? sum_im : r_acc_im + sum_im;
        end
        if (r_l2) begin
            r_yr <= round_sat(r_acc_re);
            r_yi <= round_sat(r_acc_im);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_f1   <= 1'b0;
            r_l1   <= 1'b0;
            r_l2   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_v1   <= i_ctl.en;
            r_f1   <= i_ctl.first;
            r_l1   <= i_ctl.last;
            r_l2   <= r_v1 && r_l1;
            r_done <= r_l2;
        end
    end

    assign o_done = r_done;
    assign o_yr   = r_yr;
    assign o_yi   = r_yi;

endmodule

FILE: hdl/ftdf_trig.sv
// Sine/cosine generator: quarter-wave odd polynomial evaluated in Q30 on one shared
// 31x31 multiplier, stepping through U2, H1 to H4 and OUT for each value. Depends on ftdf_pkg.
module ftdf_trig #(
    parameter int SAMPLE_BITS     = ftdf_pkg::SAMPLE_BITS_DEF,
    parameter int TRIG_TABLE_BITS = ftdf_pkg::TRIG_TABLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [TRIG_TABLE_BITS-1:0]    i_index,
    output logic                          o_done,
    output logic signed [SAMPLE_BITS-1:0] o_sin,
    output logic signed [SAMPLE_BITS-1:0] o_cos
);
    import ftdf_pkg::*;

    localparam int TB   = TRIG_TABLE_BITS;
    localparam int QB   = TB - 2;
    localparam int MW   = QB + 1;
    localparam int FRAC = SAMPLE_BITS - 1;
    localparam int USH  = 30 - QB;
    localparam int RSH  = 30 - FRAC;
    localparam logic [TB-1:0]   QTR    = TB'(1) << QB;
    localparam logic [MW-1:0]   QTR_M  = MW'(1) << QB;
    localparam logic [31:0]     RND    = 32'(1) << (RSH - 1);
    localparam logic [31:0]     SMAX32 = 32'((1 << FRAC) - 1);
    localparam logic [31:0]     POLY_C [5] = '{32'd172273, 32'd5026994, 32'd85569306,
                                              32'd693598668, 32'd1686629713};
    localparam logic [2:0] STEP_U2  = 3'd0;
    localparam logic [2:0] STEP_H1  = 3'd1;
    localparam logic [2:0] STEP_H2  = 3'd2;
    localparam logic [2:0] STEP_H3  = 3'd3;
    localparam logic [2:0] STEP_H4  = 3'd4;
    localparam logic [2:0] STEP_OUT = 3'd5;

    logic                          r_busy, r_which, r_done;
    logic [2:0]                    r_step;
    logic [TB-1:0]                 r_idx;
    logic [30:0]                   r_u2, r_p;
    logic signed [SAMPLE_BITS-1:0] r_sin, r_cos;

    logic [TB-1:0]                 idx_eff;
    logic [1:0]                    quad;
    logic [QB-1:0]                 rem;
    logic [MW-1:0]                 m;
    logic [30:0]                   u, op_a, op_b;
    logic [61:0]                   prod;
    logic [31:0]                   s32, rr, mag;
    logic signed [SAMPLE_BITS-1:0] val, res;

    // quadrant folding: cosine is the sine a quarter turn ahead
    assign idx_eff = r_idx + (r_which ? QTR : '0);
    assign quad    = idx_eff[TB-1 -: 2];
    assign rem     = idx_eff[QB-1:0];
    assign m       = quad[0] ? (QTR_M - {1'b0, rem}) : {1'b0, rem};
    assign u       = 31'(m) << USH;

    assign op_a = (r_step == STEP_U2 || r_step == STEP_OUT) ? u : r_u2;
    assign op_b = (r_step == STEP_U2) ? u : r_p;
    assign prod = 62'(op_a) * 62'(op_b);

    assign s32 = prod[61:30];
    assign rr  = (s32 + RND) >> RSH;
    assign mag = (rr > SMAX32) ? SMAX32 : rr;
    assign val = SAMPLE_BITS'(mag);
    assign res = quad[1] ? -val : val;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_idx <= i_index;
        end
        if (r_busy) begin
            case (r_step)
                STEP_U2: begin
                    r_u2 <= prod[60:30];
                    r_p  <= 31'(POLY_C[0]);
                end
                STEP_H1: r_p <= 31'(POLY_C[1] - prod[61:30]);
                STEP_H2: r_p <= 31'(POLY_C[2] - prod[61:30]);
                STEP_H3: r_p <= 31'(POLY_C[3] - prod[61:30]);
                STEP_H4: r_p <= 31'(POLY_C[4] - prod[61:30]);
                STEP_OUT: begin
                    if (r_which) begin
                        r_cos <= res;
                    end else begin
                        r_sin <= res;
                    end
                end
                default: r_p <= r_p;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_which <= 1'b0;
            r_step  <= STEP_U2;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_which <= 1'b0;
                r_step  <= STEP_U2;
            end else if (r_busy) begin
                if (r_step == STEP_OUT) begin
                    r_step <= STEP_U2;
                    if (r_which) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end else begin
                        r_which <= 1'b1;
                    end
                end else begin
                    r_step <= r_step + 3'd1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_sin  = r_sin;
    assign o_cos  = r_cos;

endmodule

FILE: hdl/freq_translating_decimating_fir.sv
// Frequency-translating decimating FIR, top level: APB registers, sample window and tap
// memories, sequencer around one shared complex MAC and the sine/cosine unit. Uses ftdf_pkg.
// Tap loads and samples that produce no output leave the sequencer idle, so input stays ready.
// A sample that produces an output holds the input off through S_FILT, S_FWAIT, S_ROT, S_RWAIT
// and S_PUSH; S_PUSH also waits while an earlier result is still held at the output.
// Reset (synchronous, active low) clears counters, phase and registers; memories are not cleared.
module freq_translating_decimating_fir #(
    parameter int MAX_TAPS        = ftdf_pkg::MAX_TAPS_DEF,
    parameter int SAMPLE_BITS     = ftdf_pkg::SAMPLE_BITS_DEF,
    parameter int TRIG_TABLE_BITS = ftdf_pkg::TRIG_TABLE_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ftdf_pkg::PADDR_W-1:0]       paddr,
    input  logic [ftdf_pkg::PDATA_W-1:0]       pwdata,
    output logic [ftdf_pkg::PDATA_W-1:0]       prdata,
    output logic                               pready,
    // input channel
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_action,
    input  logic [ftdf_pkg::TAP_IDX_W-1:0]     i_tap_index,
    input  logic signed [SAMPLE_BITS-1:0]      i_tap_re,
    input  logic signed [SAMPLE_BITS-1:0]      i_tap_im,
    input  logic signed [SAMPLE_BITS-1:0]      i_sample_re,
    input  logic signed [SAMPLE_BITS-1:0]      i_sample_im,
    // output channel
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [SAMPLE_BITS-1:0]      o_out_re,
    output logic signed [SAMPLE_BITS-1:0]      o_out_im
);
    import ftdf_pkg::*;

    localparam int W       = SAMPLE_BITS;
    localparam int AW      = $clog2(MAX_TAPS);
    localparam int ACC_W   = 2 * W + $clog2(MAX_TAPS) + 1;
    localparam int CNT_MAX = (1 << CNT_W) - 1;
    localparam int SW      = ((AW > CNT_W) ? AW : CNT_W) + 1;
    localparam logic [CNT_W-1:0] NMAX      = CNT_W'((MAX_TAPS < CNT_MAX) ? MAX_TAPS : CNT_MAX);
    localparam logic [AW-1:0]    LAST_ADDR = AW'(MAX_TAPS - 1);

    // One-hot sequencer states
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,  // take transactions
        S_FILT  = 6'b000010,  // stream window x taps into the MAC
        S_FWAIT = 6'b000100,  // drain the MAC, wait for sine/cosine
        S_ROT   = 6'b001000,  // issue the rotation product
        S_RWAIT = 6'b010000,  // drain the rotation
        S_PUSH  = 6'b100000   // hand the result to the output register
    } t_state;

    // ---------------------------------------------------------------------------------------
    // Registers and next values
    // ---------------------------------------------------------------------------------------
    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_tap_count, r_decimation;
    logic [PHASE_W-1:0]  r_phase_step;
    logic [CNT_W-1:0]    r_fill, n_fill, r_skip, n_skip, r_left, n_left;
    logic [PHASE_W-1:0]  r_phase, n_phase;
    logic [AW-1:0]       r_wp, n_wp, r_rp, n_rp, r_k, n_k;
    t_mac_ctl            r_mac, n_mac;
    logic                r_use_rot;
    logic                r_filt_ok, n_filt_ok, r_trig_ok, n_trig_ok;
    logic                r_out_valid, n_out_valid;
    logic signed [W-1:0] r_out_re, r_out_im;

    // ---------------------------------------------------------------------------------------
    // Combinational helpers
    // ---------------------------------------------------------------------------------------
    logic                 in_acc, cfg_we, emit, samp_we, tap_we, tap_idx_ok, load_out;
    logic [REG_IDX_W-1:0] reg_sel;
    logic [CNT_W-1:0]     n_taps, dec_eff, fill_inc;
    logic [CNT_W:0]       skip_inc;
    logic [AW-1:0]        wp_inc, rp_inc, rp_start, tap_waddr;
    logic [SW-1:0]        wp_ext, n_ext;
    logic [2*W-1:0]       samp_q, tap_q;
    logic signed [W-1:0]  mac_xr, mac_xi, mac_tr, mac_ti, mac_yr, mac_yi;
    logic signed [W-1:0]  trig_sin, trig_cos;
    logic                 mac_done, trig_done;

    assign in_acc = i_in_valid && o_in_ready;

    // ---------------------------------------------------------------------------------------
    // Configuration registers. Write them only while the block is idle.
    // ---------------------------------------------------------------------------------------
    assign cfg_we  = psel && penable && pwrite;
    assign reg_sel = paddr[PADDR_W-1:2];
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_count  <= TAP_COUNT_RST;
            r_decimation <= DECIMATION_RST;
            r_phase_step <= '0;
        end else if (cfg_we) begin
            case (reg_sel)
                REG_TAP_COUNT:  r_tap_count  <= pwdata[CNT_W-1:0];
                REG_DECIMATION: r_decimation <= pwdata[CNT_W-1:0];
                REG_PHASE_STEP: r_phase_step <= pwdata[PHASE_W-1:0];
                default:        r_phase_step <= r_phase_step;  // unknown register: drop
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_TAP_COUNT:  prdata = PDATA_W'(r_tap_count);
            REG_DECIMATION: prdata = PDATA_W'(r_decimation);
            REG_PHASE_STEP: prdata = PDATA_W'(r_phase_step);
            default:        prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------------------------------
    // Effective tap count (clamped to 1..MAX_TAPS) and decimation (0 acts as 1)
    // ---------------------------------------------------------------------------------------
    assign n_taps  = (r_tap_count == '0) ? CNT_W'(1)
                   : ((r_tap_count > NMAX) ? NMAX : r_tap_count);
    assign dec_eff = (r_decimation == '0) ? CNT_W'(1) : r_decimation;
    assign fill_inc = r_fill + CNT_W'(1);
    assign skip_inc = {1'b0, r_skip} + (CNT_W + 1)'(1);

    // Circular window: r_wp is the next write slot, so the newest sample sits at r_wp - 1.
    // The oldest sample of the window meets tap 0 at slot wp_inc - n_taps (mod MAX_TAPS).
    assign wp_inc   = (r_wp == LAST_ADDR) ? '0 : r_wp + AW'(1);
    assign rp_inc   = (r_rp == LAST_ADDR) ? '0 : r_rp + AW'(1);
    assign wp_ext   = SW'(wp_inc);
    assign n_ext    = SW'(n_taps);
    assign rp_start = (wp_ext >= n_ext) ? AW'(wp_ext - n_ext)
                                        : AW'(wp_ext + SW'(MAX_TAPS) - n_ext);

    assign tap_idx_ok = 32'(i_tap_index) < 32'(MAX_TAPS);
    assign tap_waddr  = AW'(i_tap_index);

    // ---------------------------------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_skip      = r_skip;
        n_phase     = r_phase;
        n_wp        = r_wp;
        n_rp        = r_rp;
        n_k         = r_k;
        n_left      = r_left;
        n_mac       = '0;
        n_filt_ok   = r_filt_ok;
        n_trig_ok   = r_trig_ok || trig_done;
        n_out_valid = r_out_valid && !i_out_ready;
        load_out    = 1'b0;
        emit        = 1'b0;
        samp_we     = 1'b0;
        tap_we      = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_action == ACT_TAP) begin
                        // tap load: counters stay put, out-of-range index is dropped
                        tap_we = tap_idx_ok;
                    end else begin
                        samp_we = 1'b1;
                        n_wp    = wp_inc;
                        if (r_fill < n_taps) begin
                            n_fill = fill_inc;
                            if (fill_inc == n_taps) begin
                                emit   = 1'b1;
                                n_skip = '0;
                            end
                        end else if (skip_inc >= {1'b0, dec_eff}) begin
                            emit   = 1'b1;
                            n_skip = '0;
                        end else begin
                            n_skip = skip_inc[CNT_W-1:0];
                        end
                        if (emit) begin
                            // start the filter pass; phase for this output goes to the trig unit
                            n_state   = S_FILT;
                            n_rp      = rp_start;
                            n_k       = '0;
                            n_left    = n_taps;
                            n_phase   = r_phase + r_phase_step;
                            n_filt_ok = 1'b0;
                            n_trig_ok = 1'b0;
                        end
                    end
                end
            end
            S_FILT: begin
                // read addresses go out now; the operands return next cycle with these flags
                n_mac.en    = 1'b1;
                n_mac.first = (r_k == '0);
                n_mac.last  = (r_left == CNT_W'(1));
                n_rp        = rp_inc;
                n_k         = r_k + AW'(1);
                n_left      = r_left - CNT_W'(1);
                if (r_left == CNT_W'(1)) begin
                    n_state = S_FWAIT;
                end
            end
            S_FWAIT: begin
                if (mac_done) begin
                    n_filt_ok = 1'b1;
                end
                if (r_filt_ok && r_trig_ok) begin
                    n_state = S_ROT;
                end
            end
            S_ROT: begin
                // single-term sum: filtered value times (cos + j sin)
                n_mac     = '{en: 1'b1, first: 1'b1, last: 1'b1};
                n_filt_ok = 1'b0;
                n_state   = S_RWAIT;
            end
            S_RWAIT: begin
                if (mac_done) begin
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                // hold until the output register is free or being emptied this cycle
                if (!r_out_valid || i_out_ready) begin
                    load_out    = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_skip      <= '0;
            r_phase     <= '0;
            r_wp        <= '0;
            r_rp        <= '0;
            r_k         <= '0;
            r_left      <= '0;
            r_mac       <= '0;
            r_use_rot   <= 1'b0;
            r_filt_ok   <= 1'b0;
            r_trig_ok   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_skip      <= n_skip;
            r_phase     <= n_phase;
            r_wp        <= n_wp;
            r_rp        <= n_rp;
            r_k         <= n_k;
            r_left      <= n_left;
            r_mac       <= n_mac;
            r_use_rot   <= (r_state == S_ROT);
            r_filt_ok   <= n_filt_ok;
            r_trig_ok   <= n_trig_ok;
            r_out_valid <= n_out_valid;
        end
    end

    // output register (payload, no reset)
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_re <= mac_yr;
            r_out_im <= mac_yi;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_re    = r_out_re;
    assign o_out_im    = r_out_im;

    // ---------------------------------------------------------------------------------------
    // Memories: sample window (circular) and tap store, both {re, im}
    // ---------------------------------------------------------------------------------------
    ftdf_ram #(
        .WIDTH (2 * W),
        .DEPTH (MAX_TAPS)
    ) u_samp_ram (
        .i_clk   (i_clk),
        .i_we    (samp_we),
        .i_waddr (r_wp),
        .i_wdata ({i_sample_re, i_sample_im}),
        .i_raddr (r_rp),
        .o_rdata (samp_q)
    );

    ftdf_ram #(
        .WIDTH (2 * W),
        .DEPTH (MAX_TAPS)
    ) u_tap_ram (
        .i_clk   (i_clk),
        .i_we    (tap_we),
        .i_waddr (tap_waddr),
        .i_wdata ({i_tap_re, i_tap_im}),
        .i_raddr (r_k),
        .o_rdata (tap_q)
    );

    // ---------------------------------------------------------------------------------------
    // Shared complex MAC: filter pass uses memory data, rotation pass reuses the filter sum
    // ---------------------------------------------------------------------------------------
    assign mac_xr = r_use_rot ? mac_yr   : samp_q[2*W-1:W];
    assign mac_xi = r_use_rot ? mac_yi   : samp_q[W-1:0];
    assign mac_tr = r_use_rot ? trig_cos : tap_q[2*W-1:W];
    assign mac_ti = r_use_rot ? trig_sin : tap_q[W-1:0];

    ftdf_cmac #(
        .SAMPLE_BITS (W),
        .ACC_W       (ACC_W)
    ) u_cmac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (r_mac),
        .i_xr    (mac_xr),
        .i_xi    (mac_xi),
        .i_tr    (mac_tr),
        .i_ti    (mac_ti),
        .o_done  (mac_done),
        .o_yr    (mac_yr),
        .o_yi    (mac_yi)
    );

    // sine/cosine of the phase before this output's advance; runs alongside the filter pass
    ftdf_trig #(
        .SAMPLE_BITS     (W),
        .TRIG_TABLE_BITS (TRIG_TABLE_BITS)
    ) u_trig (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (emit),
        .i_index (r_phase[PHASE_W-1 -: TRIG_TABLE_BITS]),
        .o_done  (trig_done),
        .o_sin   (trig_sin),
        .o_cos   (trig_cos)
    );

`ifndef SYNTHESIS
    // A finished MAC sum only shows up while the sequencer is draining.
    a_mac_done_when_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mac_done |-> (r_state == S_FWAIT || r_state == S_RWAIT))
        else $error("MAC result outside a drain state");

    // Sine/cosine finishes before the rotation is issued.
    a_trig_done_in_filter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        trig_done |-> (r_state == S_FILT || r_state == S_FWAIT))
        else $error("trig result arrived outside the filter pass");

    // The tap stream never runs with an empty count.
    a_filt_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FILT) |-> (r_left != '0))
        else $error("filter pass with no taps left");

    // A result waiting at the output is not replaced before it is taken.
    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> (r_out_valid && $stable(r_out_re)
                                           && $stable(r_out_im)))
        else $error("pending result overwritten");
`endif

endmodule

FILE: verif/tb_top.sv
// Self-checking testbench for freq_translating_decimating_fir: valid/ready streams, APB writes,
// and a bit-exact shadow of the filter, decimator and phase rotator inside tb_top.
// Depends on hdl/ftdf_pkg.sv and hdl/freq_translating_decimating_fir.sv.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ftdf_pkg::*;

    localparam int NTAPS     = MAX_TAPS_DEF;
    localparam int SBITS     = SAMPLE_BITS_DEF;
    // The shadow rotator below is written for a 1024-entry table (TRIG_TABLE_BITS_DEF = 10).
    localparam int TRIG_BITS = TRIG_TABLE_BITS_DEF;

    // Settle for longer than the longest output pass before touching registers or declaring the run over.
    localparam int SETTLE_CYCLES = 300;
    // Slowest legal run: ~1450 transactions, each with a full-length filter pass, the longest
    // output stall and a gap on the input side; take that several times over.
    localparam int CYCLE_LIMIT   = 2_000_000;

    localparam logic [REG_IDX_W-1:0] REG_UNUSED = REG_IDX_W'(3);

    typedef struct {
        logic                    action;
        logic [TAP_IDX_W-1:0]    tap_index;
        logic signed [SBITS-1:0] tap_re;
        logic signed [SBITS-1:0] tap_im;
        logic signed [SBITS-1:0] sample_re;
        logic signed [SBITS-1:0] sample_im;
    } t_fir_txn;

    typedef struct {
        logic signed [SBITS-1:0] re;
        logic signed [SBITS-1:0] im;
    } t_iq;

    // ---------------------------------------------------------------------------------
    // Clock, reset and DUT-facing signals (all driven inputs start at known values)
    // ---------------------------------------------------------------------------------
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                    psel    = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite  = 1'b0;
    logic [PADDR_W-1:0]      paddr   = '0;
    logic [PDATA_W-1:0]      pwdata  = '0;
    logic [PDATA_W-1:0]      prdata;
    logic                    pready;

    logic                    i_in_valid  = 1'b0;
    logic                    o_in_ready;
    logic                    i_action    = ACT_SAMPLE;
    logic [TAP_IDX_W-1:0]    i_tap_index = '0;
    logic signed [SBITS-1:0] i_tap_re    = '0;
    logic signed [SBITS-1:0] i_tap_im    = '0;
    logic signed [SBITS-1:0] i_sample_re = '0;
    logic signed [SBITS-1:0] i_sample_im = '0;

    logic                    o_out_valid;
    logic                    i_out_ready = 1'b0;
    logic signed [SBITS-1:0] o_out_re;
    logic signed [SBITS-1:0] o_out_im;

    always #5 i_clk = ~i_clk;

    freq_translating_decimating_fir uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_action    (i_action),
        .i_tap_index (i_tap_index),
        .i_tap_re    (i_tap_re),
        .i_tap_im    (i_tap_im),
        .i_sample_re (i_sample_re),
        .i_sample_im (i_sample_im),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_re    (o_out_re),
        .o_out_im    (o_out_im)
    );

    // ---------------------------------------------------------------------------------
    // Shadow of the filter: window, taps, counters, phase and registers
    // ---------------------------------------------------------------------------------
    logic signed [SBITS-1:0] shadow_win_re [NTAPS];
    logic signed [SBITS-1:0] shadow_win_im [NTAPS];
    logic signed [SBITS-1:0] shadow_tap_re [NTAPS];
    logic signed [SBITS-1:0] shadow_tap_im [NTAPS];
    int unsigned             shadow_fill;
    int unsigned             shadow_skip;
    logic [PHASE_W-1:0]      shadow_phase;
    logic [CNT_W-1:0]        cfg_tap_count;
    logic [CNT_W-1:0]        cfg_decimation;
    logic [PHASE_W-1:0]      cfg_phase_step;

    t_iq pending_outputs[$];

    int n_fail      = 0;
    int n_reported  = 0;
    int n_outputs   = 0;

    // Sender pacing: bursts of random length separated by random gaps.
    int gaps_on     = 0;
    int max_gap     = 1;
    int burst_left  = 0;

    // Round half up at bit 15, then clamp to the signed 16-bit range.
    function automatic logic signed [SBITS-1:0] round_sat(input longint acc);
        longint r;
        r = (acc + 64'sd16384) >>> 15;
        if (r > 64'sd32767)
            return 16'sh7fff;
        if (r < -64'sd32768)
            return 16'sh8000;
        return r[SBITS-1:0];
    endfunction

    // sin(pi/2 * m/256) in Q1.15 from the odd degree-9 polynomial, Q30 truncating products.
    function automatic longint quarter_wave(input logic [8:0] m);
        longint unsigned u, u2, p, s, r;
        u  = 64'(m) << 22;
        u2 = (u * u) >> 30;
        p  = 64'd172273;
        p  = 64'd5026994 - ((u2 * p) >> 30);
        p  = 64'd85569306 - ((u2 * p) >> 30);
        p  = 64'd693598668 - ((u2 * p) >> 30);
        p  = 64'd1686629713 - ((u2 * p) >> 30);
        s  = (u * p) >> 30;
        r  = (s + 64'd16384) >> 15;
        if (r > 64'd32767)
            r = 64'd32767;
        return longint'(r);
    endfunction

    // Fold the full turn onto the quarter wave by quadrant.
    function automatic longint trig_sin(input logic [TRIG_BITS-1:0] idx);
        case (idx[9:8])
            2'd0:    return quarter_wave({1'b0, idx[7:0]});
            2'd1:    return quarter_wave(9'd256 - idx[7:0]);
            2'd2:    return -quarter_wave({1'b0, idx[7:0]});
            default: return -quarter_wave(9'd256 - idx[7:0]);
        endcase
    endfunction

    // Advance the shadow by one accepted transaction; queue the output it causes, if any.
    task automatic shadow_accept(input t_fir_txn t);
        int     k, n, dec;
        bit     emit;
        longint acc_re, acc_im, xr, xi, tr, ti, yr, yi, sn, cs;
        logic [TRIG_BITS-1:0] ph_idx;
        t_iq    res;
        emit   = 1'b0;
        acc_re = 0;
        acc_im = 0;
        if (t.action == ACT_TAP) begin
            // Tap loads leave the counters alone.
            shadow_tap_re[t.tap_index] = t.tap_re;
            shadow_tap_im[t.tap_index] = t.tap_im;
        end else begin
            for (k = 0; k < NTAPS - 1; k++) begin
                shadow_win_re[k] = shadow_win_re[k + 1];
                shadow_win_im[k] = shadow_win_im[k + 1];
            end
            shadow_win_re[NTAPS - 1] = t.sample_re;
            shadow_win_im[NTAPS - 1] = t.sample_im;

            // Clamp the tap count to 1..NTAPS; a decimation of zero acts as one.
            n = int'(cfg_tap_count);
            if (n < 1)
                n = 1;
            if (n > NTAPS)
                n = NTAPS;
            dec = (cfg_decimation == '0) ? 1 : int'(cfg_decimation);

            if (shadow_fill < n) begin
                shadow_fill++;
                if (shadow_fill == n) begin
                    emit = 1'b1;
                    shadow_skip = 0;
                end
            end else begin
                shadow_skip++;
                if (shadow_skip >= dec) begin
                    emit = 1'b1;
                    shadow_skip = 0;
                end
            end

            if (emit) begin
                // Oldest sample of the window meets tap 0.
                for (k = 0; k < n; k++) begin
                    xr = shadow_win_re[NTAPS - n + k];
                    xi = shadow_win_im[NTAPS - n + k];
                    tr = shadow_tap_re[k];
                    ti = shadow_tap_im[k];
                    acc_re += xr * tr - xi * ti;
                    acc_im += xr * ti + xi * tr;
                end
                yr = round_sat(acc_re);
                yi = round_sat(acc_im);

                ph_idx = shadow_phase[PHASE_W-1 -: TRIG_BITS];
                sn = trig_sin(ph_idx);
                cs = trig_sin(ph_idx + TRIG_BITS'(256));
                shadow_phase += cfg_phase_step;

                res.re = round_sat(yr * cs - yi * sn);
                res.im = round_sat(yr * sn + yi * cs);
                pending_outputs.push_back(res);
            end
        end
    endtask

    // ---------------------------------------------------------------------------------
    // Stimulus helpers; every task is entered and left just after a rising edge
    // ---------------------------------------------------------------------------------
    function automatic logic signed [SBITS-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2:       return 16'sh0000;
            3:       return 16'shffff;
            default: return SBITS'($urandom);
        endcase
    endfunction

    function automatic t_fir_txn make_sample(input logic signed [SBITS-1:0] re,
                                             input logic signed [SBITS-1:0] im);
        t_fir_txn t;
        t.action    = ACT_SAMPLE;
        t.tap_index = TAP_IDX_W'($urandom);
        t.tap_re    = SBITS'($urandom);
        t.tap_im    = SBITS'($urandom);
        t.sample_re = re;
        t.sample_im = im;
        return t;
    endfunction

    function automatic t_fir_txn make_tap_load(input int idx,
                                               input logic signed [SBITS-1:0] re,
                                               input logic signed [SBITS-1:0] im);
        t_fir_txn t;
        t.action    = ACT_TAP;
        t.tap_index = TAP_IDX_W'(idx);
        t.tap_re    = re;
        t.tap_im    = im;
        t.sample_re = SBITS'($urandom);
        t.sample_im = SBITS'($urandom);
        return t;
    endfunction

    // Drop valid and hold the input side quiet; n sets how long.
    task automatic idle_input(input int n);
        i_in_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Present one transaction and hold it until accepted. Valid is left high so a
    // back-to-back transaction does not toggle it within one time step.
    task automatic send_item(input t_fir_txn t);
        if (gaps_on != 0) begin
            if (burst_left == 0) begin
                idle_input($urandom_range(1, max_gap));
                burst_left = $urandom_range(1, 24);
            end
            burst_left--;
        end
        i_in_valid  <= 1'b1;
        i_action    <= t.action;
        i_tap_index <= t.tap_index;
        i_tap_re    <= t.tap_re;
        i_tap_im    <= t.tap_im;
        i_sample_re <= t.sample_re;
        i_sample_im <= t.sample_im;
        do @(posedge i_clk); while (!o_in_ready);
        shadow_accept(t);
    endtask

    // Wait until every queued output has arrived and the sequencer has gone quiet.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_outputs.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // APB write: setup phase, access phase completing on pready, then an idle phase with psel low
    // so the next setup phase starts in a later time step.
    task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [PDATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_TAP_COUNT:  cfg_tap_count  = val[CNT_W-1:0];
            REG_DECIMATION: cfg_decimation = val[CNT_W-1:0];
            REG_PHASE_STEP: cfg_phase_step = val[PHASE_W-1:0];
            default:        ; // unmapped index: the block ignores it
        endcase
    endtask

    task automatic configure(input int taps, input int dec, input logic [PHASE_W-1:0] step);
        reg_write(REG_TAP_COUNT, PDATA_W'(taps));
        reg_write(REG_DECIMATION, PDATA_W'(dec));
        reg_write(REG_PHASE_STEP, step);
    endtask

    // ---------------------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------------------

    // Load every tap once so no output ever reads an unwritten entry.
    task automatic test_tap_preload();
        int k;
        gaps_on = 1;
        max_gap = 4;
        for (k = 0; k < NTAPS; k++)
            send_item(make_tap_load(k, pick_value(), pick_value()));
        wait_idle();
    endtask

    // Full-scale samples and taps through a two-tap filter, a tap reload in the middle
    // of the stream, then quarter-turn rotation with decimation.
    task automatic test_corner_values();
        gaps_on = 0;
        configure(2, 1, 32'h0000_0000);
        send_item(make_tap_load(0, 16'sh8000, 16'sh0000));
        send_item(make_tap_load(1, 16'sh8000, 16'sh8000));
        send_item(make_sample(16'sh8000, 16'sh8000));
        send_item(make_sample(16'sh8000, 16'sh8000));
        send_item(make_sample(16'sh7fff, 16'sh7fff));
        send_item(make_sample(16'sh8000, 16'sh7fff));
        send_item(make_sample(16'sh0000, 16'sh0000));
        send_item(make_sample(16'sh7fff, 16'sh8000));
        send_item(make_sample(16'shffff, 16'shffff));
        send_item(make_sample(16'sh0001, 16'sh0001));
        // Reload a tap mid-stream; counters must not move.
        send_item(make_tap_load(1, 16'sh7fff, 16'sh7fff));
        send_item(make_sample(16'sh7fff, 16'sh7fff));
        send_item(make_sample(16'sh8000, 16'sh8000));
        wait_idle();
        configure(2, 3, 32'h4000_0000);
        repeat (9) send_item(make_sample(pick_value(), pick_value()));
        wait_idle();
    endtask

    // Random streams over a series of settings. Registers change between phases without
    // a reset, so every phase also covers a register change mid-stream.
    task automatic test_random_stream();
        int p, i, taps, dec, n_items;
        logic [PHASE_W-1:0] step;
        t_fir_txn t;
        for (p = 0; p < 16; p++) begin
            case (p)
                0: begin
                    taps = 1;   dec = 1;   step = 32'h0000_0000; n_items = 80;
                end
                1: begin
                    taps = 256; dec = 2;   step = 32'hffff_ffff; n_items = 320;
                end
                2: begin
                    taps = 0;   dec = 0;   step = 32'h8000_0000; n_items = 40;
                end
                3: begin
                    taps = 3;   dec = 256; step = $urandom;      n_items = 260;
                end
                default: begin
                    taps = ($urandom_range(0, 3) != 0) ? $urandom_range(1, 16)
                                                       : $urandom_range(17, 256);
                    dec  = ($urandom_range(0, 9) < 7)  ? $urandom_range(1, 6)
                                                       : $urandom_range(7, 256);
                    step = $urandom;
                    n_items = 40;
                end
            endcase
            configure(taps, dec, step);
            if (p == 2)
                reg_write(REG_UNUSED, $urandom);

            // Rotate through no gaps, short gaps and long gaps on the input side.
            gaps_on    = (p % 3 != 0);
            max_gap    = (p % 3 == 1) ? 3 : 12;
            burst_left = 0;
            for (i = 0; i < n_items; i++) begin
                if ($urandom_range(0, 9) == 0)
                    t = make_tap_load($urandom_range(0, NTAPS - 1), pick_value(), pick_value());
                else
                    t = make_sample(pick_value(), pick_value());
                send_item(t);
            end
            wait_idle();
        end
    endtask

    // ---------------------------------------------------------------------------------
    // Output side: stall pattern and result checking
    // ---------------------------------------------------------------------------------

    // Alternate between always ready, coin-flip ready and mostly ready with long stalls.
    initial begin : out_ready_pattern
        int mode, span, stall_left;
        stall_left = 0;
        forever begin
            mode = $urandom_range(0, 2);
            span = $urandom_range(50, 300);
            repeat (span) begin
                @(posedge i_clk);
                case (mode)
                    0: i_out_ready <= 1'b1;
                    1: i_out_ready <= 1'($urandom_range(0, 1));
                    default: begin
                        if (stall_left > 0) begin
                            stall_left--;
                            i_out_ready <= 1'b0;
                        end else if ($urandom_range(0, 15) == 0) begin
                            stall_left = $urandom_range(1, 30);
                            i_out_ready <= 1'b0;
                        end else begin
                            i_out_ready <= 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    task automatic note_failure(input string msg);
        n_fail++;
        if (n_reported < 10) begin
            n_reported++;
            $display("%s", msg);
        end
    endtask

    // Compare every accepted output against the oldest prediction.
    always @(posedge i_clk) begin
        t_iq want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_outputs.size() == 0) begin
                note_failure($sformatf("output %0d arrived with nothing pending: re=%0d im=%0d",
                                       n_outputs, o_out_re, o_out_im));
            end else begin
                want = pending_outputs.pop_front();
                if (o_out_re !== want.re || o_out_im !== want.im)
                    note_failure($sformatf(
                        "output %0d mismatch: expected re=%0d im=%0d, got re=%0d im=%0d",
                        n_outputs, want.re, want.im, o_out_re, o_out_im));
            end
            n_outputs++;
        end
    end

    // ---------------------------------------------------------------------------------
    // Watchdog
    // ---------------------------------------------------------------------------------
    initial begin : watchdog
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", CYCLE_LIMIT);
        $display("simulation failed");
        $finish;
    end

    // ---------------------------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------------------------
    initial begin : main_sequence
        int k;
        for (k = 0; k < NTAPS; k++) begin
            shadow_win_re[k] = '0;
            shadow_win_im[k] = '0;
            shadow_tap_re[k] = '0;
            shadow_tap_im[k] = '0;
        end
        shadow_fill    = 0;
        shadow_skip    = 0;
        shadow_phase   = '0;
        cfg_tap_count  = TAP_COUNT_RST;
        cfg_decimation = DECIMATION_RST;
        cfg_phase_step = '0;

        // Hold reset once at the start, then release it.
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_tap_preload();
        test_corner_values();
        test_random_stream();

        wait_idle();
        if (pending_outputs.size() != 0) begin
            n_fail += pending_outputs.size();
            $display("%0d predicted outputs never arrived", pending_outputs.size());
        end
        if (n_fail == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hdl/ftdf_pkg.sv
hdl/ftdf_ram.sv
hdl/ftdf_cmac.sv
hdl/ftdf_trig.sv
hdl/freq_translating_decimating_fir.sv
verif/tb_top.sv
